/* hw/rtl/pdcf_pkg.sv */
// shared types, constants and helpers for the packet deframer and channel filter
package pdcf_pkg;

   localparam int CHANNELS_DEF    = 8;
   localparam int DATA_OFFSET_DEF = 6;

   localparam int SAMPLE_W = 32;
   localparam int VALUE_W  = 48;
   localparam int GAIN_W   = 17;
   localparam int LIMIT_W  = 16;
   localparam int MARKER_W = 8;
   localparam int MASK_W   = 8;
   localparam int INDEX_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int MAG_W    = VALUE_W + 1;
   localparam int HI_W     = MAG_W - 16 + GAIN_W;
   localparam int LO_W     = 16 + GAIN_W;
   localparam int WIDE_W   = VALUE_W + 3;

   localparam logic [GAIN_W-1:0] UNITY = 17'd65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_MARKER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_MARKER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTH_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DC_GAIN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DC_STEP_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_EN    = 3'd5;

   localparam logic [MARKER_W-1:0] START_MARKER_RST = 8'd160;
   localparam logic [MARKER_W-1:0] END_MARKER_RST   = 8'd192;
   localparam logic [GAIN_W-1:0]   SMOOTH_GAIN_RST  = 17'd19661;
   localparam logic [GAIN_W-1:0]   DC_GAIN_RST      = 17'd6554;
   localparam logic [LIMIT_W-1:0]  DC_LIMIT_RST     = 16'd66;
   localparam logic [MASK_W-1:0]   CHANNEL_EN_RST   = 8'd255;

   localparam logic signed [WIDE_W-1:0] MAX48_WIDE = 51'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] MIN48_WIDE = 51'sh7_8000_0000_0000;

   typedef enum logic [5:0] {
      ST_RECV = 6'b000001,
      ST_DIFF = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_SUM  = 6'b001000,
      ST_UPD  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctl_type;

   typedef struct packed {
      logic diff;
      logic mul;
      logic sum;
   } stage_ctl_type;

   function automatic logic signed [VALUE_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v > MAX48_WIDE) begin
         r = MAX48_WIDE[VALUE_W-1:0];
      end else if (v < MIN48_WIDE) begin
         r = MIN48_WIDE[VALUE_W-1:0];
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/pdcf_cell.sv */
// one channel cell: sample bytes shift through, filter state rotates through
module pdcf_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pdcf_pkg::cell_ctl_type                 ctl,
   input  logic [pdcf_pkg::MARKER_W-1:0]          byte_in,
   input  logic signed [pdcf_pkg::SAMPLE_W-1:0]   smp_in,
   input  logic signed [pdcf_pkg::VALUE_W-1:0]    smooth_in,
   input  logic signed [pdcf_pkg::VALUE_W-1:0]    dc_in,
   output logic signed [pdcf_pkg::SAMPLE_W-1:0]   smp_out,
   output logic signed [pdcf_pkg::VALUE_W-1:0]    smooth_out,
   output logic signed [pdcf_pkg::VALUE_W-1:0]    dc_out
);

   logic signed [pdcf_pkg::SAMPLE_W-1:0] smp_ff, smp_in_w;
   logic signed [pdcf_pkg::VALUE_W-1:0]  smooth_ff, smooth_in_w;
   logic signed [pdcf_pkg::VALUE_W-1:0]  dc_ff, dc_in_w;

   always_comb begin
      smp_in_w    = smp_ff;
      smooth_in_w = smooth_ff;
      dc_in_w     = dc_ff;
      if (ctl.shift) begin
         // new byte enters at the top, low byte moves on to the lower cell
         smp_in_w = {byte_in, smp_ff[pdcf_pkg::SAMPLE_W-1:8]};
      end else if (ctl.rotate) begin
         smp_in_w    = smp_in;
         smooth_in_w = smooth_in;
         dc_in_w     = dc_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         dc_ff     <= '0;
      end else begin
         smooth_ff <= smooth_in_w;
         dc_ff     <= dc_in_w;
      end
   end

   assign smp_out    = smp_ff;
   assign smooth_out = smooth_ff;
   assign dc_out     = dc_ff;

endmodule

/* hw/rtl/pdcf_scale.sv */
// gain scaling pipeline: sign(e) * floor(|e| * g / 65536) over three stages
module pdcf_scale (
   input  logic                                  clock,
   input  pdcf_pkg::stage_ctl_type               ctl,
   input  logic signed [pdcf_pkg::VALUE_W-1:0]   target,
   input  logic signed [pdcf_pkg::VALUE_W-1:0]   current,
   input  logic [pdcf_pkg::GAIN_W-1:0]           gain,
   output logic [pdcf_pkg::HI_W-1:0]             q_out,
   output logic                                  neg_out
);

   logic signed [pdcf_pkg::MAG_W-1:0] err;
   logic [pdcf_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in, neg2_ff, neg3_ff;
   logic [pdcf_pkg::HI_W-1:0] hi_ff, hi_in;
   logic [pdcf_pkg::LO_W-1:0] lo_ff, lo_in;
   logic [pdcf_pkg::HI_W-1:0] q_ff, q_in;

   always_comb begin
      err    = pdcf_pkg::MAG_W'(target) - pdcf_pkg::MAG_W'(current);
      neg_in = err[pdcf_pkg::MAG_W-1];
      mag_in = neg_in ? pdcf_pkg::MAG_W'(-err) : pdcf_pkg::MAG_W'(err);
      hi_in  = pdcf_pkg::HI_W'(mag_ff[pdcf_pkg::MAG_W-1:16]) * pdcf_pkg::HI_W'(gain);
      lo_in  = pdcf_pkg::LO_W'(mag_ff[15:0]) * pdcf_pkg::LO_W'(gain);
      q_in   = hi_ff + pdcf_pkg::HI_W'(lo_ff[pdcf_pkg::LO_W-1:16]);
   end

   always_ff @(posedge clock) begin
      if (ctl.diff) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (ctl.mul) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         neg2_ff <= neg_ff;
      end
      if (ctl.sum) begin
         q_ff    <= q_in;
         neg3_ff <= neg2_ff;
      end
   end

   assign q_out   = q_ff;
   assign neg_out = neg3_ff;

endmodule

/* hw/rtl/packet_deframe_channel_filter_unit.sv */
// top level: byte deframer, chain of channel cells and shared filter update
// update pass: a closing end marker starts the pass, in which each channel in turn runs
// through the shared update pipeline (difference, multiply, sum, update, output) and gives
// one result; the output step waits while a held result is not taken; no byte is taken
// during that pass
// reset: hunting for a start marker, smoothed and dc state cleared, registers at defaults
module packet_deframe_channel_filter_unit #(
   parameter int CHANNELS    = pdcf_pkg::CHANNELS_DEF,
   parameter int DATA_OFFSET = pdcf_pkg::DATA_OFFSET_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pdcf_pkg::MARKER_W-1:0]         req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [pdcf_pkg::INDEX_W-1:0]          rsp_channel_index,
   output logic signed [pdcf_pkg::SAMPLE_W-1:0]  rsp_raw_sample,
   output logic signed [pdcf_pkg::VALUE_W-1:0]   rsp_smoothed_value,
   output logic signed [pdcf_pkg::VALUE_W-1:0]   rsp_dc_estimate,
   output logic signed [pdcf_pkg::VALUE_W-1:0]   rsp_corrected_value,
   output logic                                  rsp_monitored,
   output logic                                  rsp_last_channel,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pdcf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pdcf_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int LAST_DATA = DATA_OFFSET + 4 * CHANNELS - 1;
   localparam int POS_W     = $clog2(LAST_DATA + 1);
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration registers
   logic [pdcf_pkg::MARKER_W-1:0] start_marker_ff, end_marker_ff;
   logic [pdcf_pkg::GAIN_W-1:0]   smooth_gain_ff, dc_gain_ff;
   logic [pdcf_pkg::LIMIT_W-1:0]  dc_limit_ff;
   logic [pdcf_pkg::MASK_W-1:0]   chan_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= pdcf_pkg::START_MARKER_RST;
         end_marker_ff   <= pdcf_pkg::END_MARKER_RST;
         smooth_gain_ff  <= pdcf_pkg::SMOOTH_GAIN_RST;
         dc_gain_ff      <= pdcf_pkg::DC_GAIN_RST;
         dc_limit_ff     <= pdcf_pkg::DC_LIMIT_RST;
         chan_en_ff      <= pdcf_pkg::CHANNEL_EN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pdcf_pkg::REG_START_MARKER:  start_marker_ff <= csr_data[pdcf_pkg::MARKER_W-1:0];
            pdcf_pkg::REG_END_MARKER:    end_marker_ff   <= csr_data[pdcf_pkg::MARKER_W-1:0];
            pdcf_pkg::REG_SMOOTH_GAIN:   smooth_gain_ff  <= csr_data[pdcf_pkg::GAIN_W-1:0];
            pdcf_pkg::REG_DC_GAIN:       dc_gain_ff      <= csr_data[pdcf_pkg::GAIN_W-1:0];
            pdcf_pkg::REG_DC_STEP_LIMIT: dc_limit_ff     <= csr_data[pdcf_pkg::LIMIT_W-1:0];
            pdcf_pkg::REG_CHANNEL_EN:    chan_en_ff      <= csr_data[pdcf_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   logic [pdcf_pkg::GAIN_W-1:0] gs, gd;
   assign gs = (smooth_gain_ff > pdcf_pkg::UNITY) ? pdcf_pkg::UNITY : smooth_gain_ff;
   assign gd = (dc_gain_ff > pdcf_pkg::UNITY) ? pdcf_pkg::UNITY : dc_gain_ff;

   // sequencer and deframer state
   pdcf_pkg::state_type state_ff, state_in;
   logic in_packet_ff, in_packet_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic req_beat, close_beat, data_beat, out_go, last_ch;

   assign req_ready  = (state_ff == pdcf_pkg::ST_RECV);
   assign req_beat   = req_valid && req_ready;
   assign data_beat  = req_beat && in_packet_ff && (pos_ff < POS_W'(LAST_DATA))
                       && (pos_ff >= POS_W'(DATA_OFFSET - 1));
   assign close_beat = req_beat && in_packet_ff && (pos_ff == POS_W'(LAST_DATA))
                       && (req_rx_byte == end_marker_ff);
   assign out_go     = (state_ff == pdcf_pkg::ST_OUT) && (!rsp_valid || rsp_ready);
   assign last_ch    = (ch_ff == CH_W'(CHANNELS - 1));

   always_comb begin
      state_in     = state_ff;
      in_packet_in = in_packet_ff;
      pos_in       = pos_ff;
      ch_in        = ch_ff;
      case (state_ff)
         pdcf_pkg::ST_RECV: begin
            if (req_beat) begin
               if (!in_packet_ff) begin
                  if (req_rx_byte == start_marker_ff) begin
                     in_packet_in = 1'b1;
                     pos_in       = '0;
                  end
               end else if (pos_ff < POS_W'(LAST_DATA)) begin
                  pos_in = pos_ff + POS_W'(1);
               end else if (close_beat) begin
                  in_packet_in = 1'b0;
                  pos_in       = '0;
                  ch_in        = '0;
                  state_in     = pdcf_pkg::ST_DIFF;
               end
            end
         end
         pdcf_pkg::ST_DIFF: state_in = pdcf_pkg::ST_MUL;
         pdcf_pkg::ST_MUL:  state_in = pdcf_pkg::ST_SUM;
         pdcf_pkg::ST_SUM:  state_in = pdcf_pkg::ST_UPD;
         pdcf_pkg::ST_UPD:  state_in = pdcf_pkg::ST_OUT;
         pdcf_pkg::ST_OUT: begin
            if (out_go) begin
               ch_in    = ch_ff + CH_W'(1);
               state_in = last_ch ? pdcf_pkg::ST_RECV : pdcf_pkg::ST_DIFF;
            end
         end
         default: state_in = pdcf_pkg::ST_RECV;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdcf_pkg::ST_RECV;
         in_packet_ff <= 1'b0;
         pos_ff       <= '0;
         ch_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         in_packet_ff <= in_packet_in;
         pos_ff       <= pos_in;
         ch_ff        <= ch_in;
      end
   end

   // chain of channel cells; cell 0 feeds the update pipeline
   logic signed [pdcf_pkg::SAMPLE_W-1:0] smp_w    [CHANNELS];
   logic signed [pdcf_pkg::VALUE_W-1:0]  smooth_w [CHANNELS];
   logic signed [pdcf_pkg::VALUE_W-1:0]  dc_w     [CHANNELS];
   logic signed [pdcf_pkg::VALUE_W-1:0]  new_s_ff, new_s_in, new_d_ff, new_d_in;
   pdcf_pkg::cell_ctl_type cell_ctl;

   assign cell_ctl.shift  = data_beat;
   assign cell_ctl.rotate = out_go;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
      if (c == CHANNELS - 1) begin : g_top
         pdcf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .byte_in    (req_rx_byte),
            .smp_in     (smp_w[0]),
            .smooth_in  (new_s_ff),
            .dc_in      (new_d_ff),
            .smp_out    (smp_w[c]),
            .smooth_out (smooth_w[c]),
            .dc_out     (dc_w[c])
         );
      end else begin : g_mid
         pdcf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl),
            .byte_in    (smp_w[c+1][pdcf_pkg::MARKER_W-1:0]),
            .smp_in     (smp_w[c+1]),
            .smooth_in  (smooth_w[c+1]),
            .dc_in      (dc_w[c+1]),
            .smp_out    (smp_w[c]),
            .smooth_out (smooth_w[c]),
            .dc_out     (dc_w[c])
         );
      end
   end

   // shared update pipeline
   pdcf_pkg::stage_ctl_type stage_ctl;
   logic signed [pdcf_pkg::VALUE_W-1:0] y_w;
   logic [pdcf_pkg::HI_W-1:0] qs, qd;
   logic negs, negd;

   assign stage_ctl.diff = (state_ff == pdcf_pkg::ST_DIFF);
   assign stage_ctl.mul  = (state_ff == pdcf_pkg::ST_MUL);
   assign stage_ctl.sum  = (state_ff == pdcf_pkg::ST_SUM);
   assign y_w = {smp_w[0], 16'h0000};

   pdcf_scale u_scale_smooth (
      .clock   (clock),
      .ctl     (stage_ctl),
      .target  (y_w),
      .current (smooth_w[0]),
      .gain    (gs),
      .q_out   (qs),
      .neg_out (negs)
   );

   pdcf_scale u_scale_dc (
      .clock   (clock),
      .ctl     (stage_ctl),
      .target  (y_w),
      .current (dc_w[0]),
      .gain    (gd),
      .q_out   (qd),
      .neg_out (negd)
   );

   logic signed [pdcf_pkg::WIDE_W-1:0] qs_signed, step_s, qd_signed, step_d;
   logic [pdcf_pkg::LIMIT_W-1:0] qd_clamped;

   always_comb begin
      qs_signed  = $signed({1'b0, qs});
      step_s     = negs ? -qs_signed : qs_signed;
      // dc step is rate limited before it is applied
      qd_clamped = (qd > pdcf_pkg::HI_W'(dc_limit_ff)) ? dc_limit_ff
                                                       : qd[pdcf_pkg::LIMIT_W-1:0];
      qd_signed  = $signed(pdcf_pkg::WIDE_W'(qd_clamped));
      step_d     = negd ? -qd_signed : qd_signed;
      new_s_in   = pdcf_pkg::sat48(pdcf_pkg::WIDE_W'(smooth_w[0]) + step_s);
      new_d_in   = pdcf_pkg::sat48(pdcf_pkg::WIDE_W'(dc_w[0]) + step_d);
   end

   always_ff @(posedge clock) begin
      if (state_ff == pdcf_pkg::ST_UPD) begin
         new_s_ff <= new_s_in;
         new_d_ff <= new_d_in;
      end
   end

   // output register
   logic rsp_valid_ff;
   logic [pdcf_pkg::INDEX_W-1:0] ch_idx;
   logic signed [pdcf_pkg::VALUE_W-1:0] corr_in;

   assign ch_idx  = pdcf_pkg::INDEX_W'(ch_ff);
   assign corr_in = pdcf_pkg::sat48(pdcf_pkg::WIDE_W'(new_s_ff) - pdcf_pkg::WIDE_W'(new_d_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_go) begin
         rsp_channel_index   <= ch_idx;
         rsp_raw_sample      <= smp_w[0];
         rsp_smoothed_value  <= new_s_ff;
         rsp_dc_estimate     <= new_d_ff;
         rsp_corrected_value <= corr_in;
         rsp_monitored       <= chan_en_ff[ch_idx];
         rsp_last_channel    <= last_ch;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(LAST_DATA))
      else $error("byte position beyond last data byte");

   a_no_packet_in_pass: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> !in_packet_ff)
      else $error("packet still open during update pass");

   a_close_starts_pass: assert property (@(posedge clock) disable iff (reset)
      close_beat |=> (state_ff == pdcf_pkg::ST_DIFF) && (ch_ff == '0))
      else $error("close beat did not start update pass at channel zero");

   a_last_ends_pass: assert property (@(posedge clock) disable iff (reset)
      out_go && last_ch |=> req_ready && rsp_valid && rsp_last_channel)
      else $error("last channel result did not end update pass");

endmodule
